// File: design/assert_macros.svh
// Assertion macros shared by the stepper move profile modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: design/smpg_pkg.sv
// Package for the stepper move profile generator: opcodes, register
// indexes, command and status types, cosine table function.
package smpg_pkg;
  localparam int CosTableDepth = 256;
  localparam logic [15:0] PeriodMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TIMED = 2'd0, OP_VELOCITY = 2'd1, OP_STEP = 2'd2, OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MAX_TRAVEL = 3'd0, REG_MARGIN = 3'd1, REG_THRESHOLD = 3'd2,
    REG_STEPS_REV = 3'd3, REG_MM_REV = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_AIM, CMD_DIV_PEAK, CMD_DIV_FLAT, CMD_TIMED_DONE,
    CMD_MUL_SPS, CMD_DIV_SPS, CMD_DIV_VEL, CMD_VEL_DONE, CMD_STEP,
    CMD_DIV_T, CMD_LOOKUP, CMD_DIV_PER, CMD_TICK_DONE
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
    logic      load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic dist_zero;
    logic active;
    logic profiled;
  } status_t;

  function automatic logic signed [17:0] cos_entry(input int i, input int depth);
    logic [63:0] x, term, j;
    logic signed [63:0] acc, r;
    j = (2 * i <= depth) ? 64'(i) : 64'(depth - i);
    x = (64'd2 * 64'd843314857 * j) / 64'(depth);
    acc = 64'sd268435456;
    term = 64'd268435456;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x) >> 28;
      term = (term * x) >> 28;
      term = term / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc >= 0) r = $signed((64'(acc) + 64'd2048) >> 12);
    else r = -$signed((64'(-acc) + 64'd2048) >> 12);
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return 18'(r);
  endfunction
endpackage

// File: design/smpg_if.sv
// Valid/ready channel interface; payload type given as parameter.
// Depends on nothing.
interface smpg_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/smpg_divider.sv
// Restoring divider, one quotient bit a cycle, 32-bit dividend, 24-bit divisor.
// Depends on nothing.
module smpg_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [5:0]  count;
  logic [24:0] rem;
  logic [23:0] dvs;
  logic [24:0] trial;

  assign trial = {rem[23:0], quotient[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'd32;
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= trial;
        quotient <= {quotient[30:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) busy <= 1'b0;
    end
  end
endmodule

// File: design/smpg_datapath.sv
// Datapath: move state, config registers, cosine table, shared divider.
// Depends on smpg_pkg, smpg_divider and assert_macros.svh.
module smpg_datapath #(
  parameter int COS_TABLE_DEPTH = smpg_pkg::CosTableDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  smpg_pkg::cmd_t     cmd,
  output smpg_pkg::status_t  status,
  input  logic [23:0]        in_target,
  input  logic [15:0]        in_duration,
  input  logic [9:0]         in_speed,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic [15:0]        period,
  output logic [14:0]        compare,
  output logic               running,
  output logic               direction,
  output logic [23:0]        position,
  output logic               finished
);
  localparam int IdxW = $clog2(COS_TABLE_DEPTH);

  logic [23:0] max_travel, remaining, span, target;
  logic [15:0] margin, threshold, steps_rev, duration, elapsed, move_time;
  logic [15:0] fastest, cur_period, peak;
  logic [7:0]  mm_rev;
  logic [9:0]  speed;
  logic        moving_down, active, profiled, fin;
  logic [25:0] sps;
  logic [IdxW-1:0] idx;
  logic [16:0] v;
  logic        div_start, div_busy;
  logic [31:0] div_a, div_q;
  logic [23:0] div_b;
  logic [15:0] q_clamp;
  logic [23:0] upper, pos_next;
  logic signed [17:0] cos_q;
  logic signed [17:0] cos_tab [COS_TABLE_DEPTH];

  smpg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
    localparam logic signed [17:0] Entry = smpg_pkg::cos_entry(g, COS_TABLE_DEPTH);
    assign cos_tab[g] = Entry;
  end

  assign q_clamp = (div_q == 32'd0) ? 16'd1 : (|div_q[31:16]) ? smpg_pkg::PeriodMax
                 : div_q[15:0];
  assign upper = (max_travel > {8'd0, margin}) ? max_travel - {8'd0, margin} : 24'd0;
  assign pos_next = moving_down ? position - 24'd1 : position + 24'd1;

  always_comb begin
    div_start = 1'b0;
    div_a = '0;
    div_b = span;
    unique case (cmd.code)
      smpg_pkg::CMD_DIV_PEAK: begin
        div_start = 1'b1;
        div_a = 32'(duration) * 32'd500;
      end
      smpg_pkg::CMD_DIV_FLAT: begin
        div_start = 1'b1;
        div_a = 32'(duration) * 32'd1000;
      end
      smpg_pkg::CMD_DIV_SPS: begin
        div_start = 1'b1;
        div_a = {6'd0, sps};
        div_b = {16'd0, (mm_rev == 8'd0) ? 8'd1 : mm_rev};
      end
      smpg_pkg::CMD_DIV_VEL: begin
        div_start = 1'b1;
        div_a = 32'd1000000;
        div_b = (|div_q[31:24]) ? 24'hFFFFFF : div_q[23:0];
      end
      smpg_pkg::CMD_DIV_T: begin
        div_start = 1'b1;
        div_a = {elapsed, 16'd0};
        div_b = {8'd0, move_time};
      end
      smpg_pkg::CMD_DIV_PER: begin
        div_start = 1'b1;
        div_a = {fastest, 16'd0};
        div_b = {7'd0, v};
      end
      default: ;
    endcase
  end

  assign status.div_busy = div_busy;
  assign status.dist_zero = (span == 24'd0);
  assign status.active = active;
  assign status.profiled = profiled;

  assign cos_q = cos_tab[idx];
  assign period = cur_period;
  assign compare = active ? cur_period[15:1] : 15'd0;
  assign running = active;
  assign direction = moving_down;
  assign finished = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_travel <= 24'hFFFFFF;
      margin <= '0;
      threshold <= 16'd667;
      steps_rev <= 16'd200;
      mm_rev <= 8'd8;
      position <= '0;
      remaining <= '0;
      elapsed <= '0;
      move_time <= '0;
      fastest <= smpg_pkg::PeriodMax;
      cur_period <= smpg_pkg::PeriodMax;
      moving_down <= 1'b0;
      active <= 1'b0;
      profiled <= 1'b0;
      fin <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          smpg_pkg::REG_MAX_TRAVEL: max_travel <= cfg_data;
          smpg_pkg::REG_MARGIN:     margin <= cfg_data[15:0];
          smpg_pkg::REG_THRESHOLD:  threshold <= cfg_data[15:0];
          smpg_pkg::REG_STEPS_REV:  steps_rev <= cfg_data[15:0];
          smpg_pkg::REG_MM_REV:     mm_rev <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        target <= in_target;
        duration <= in_duration;
        speed <= in_speed;
        fin <= 1'b0;
      end
      unique case (cmd.code)
        smpg_pkg::CMD_AIM: begin
          if (target < position) span <= position - target;
          else span <= target - position;
          if (target != position) moving_down <= (target < position);
        end
        smpg_pkg::CMD_DIV_FLAT: peak <= q_clamp;
        smpg_pkg::CMD_TIMED_DONE: begin
          elapsed <= '0;
          move_time <= duration;
          remaining <= span;
          active <= 1'b1;
          if (peak >= threshold) begin
            fastest <= q_clamp;
            cur_period <= q_clamp;
            profiled <= 1'b0;
          end else begin
            fastest <= peak;
            cur_period <= smpg_pkg::PeriodMax;
            profiled <= 1'b1;
          end
        end
        smpg_pkg::CMD_MUL_SPS: sps <= 26'(speed) * 26'(steps_rev);
        smpg_pkg::CMD_VEL_DONE: begin
          remaining <= span;
          fastest <= q_clamp;
          cur_period <= q_clamp;
          profiled <= 1'b0;
          active <= 1'b1;
        end
        smpg_pkg::CMD_STEP: begin
          position <= pos_next;
          if (remaining == 24'd1 || (moving_down && pos_next <= {8'd0, margin}) ||
              (!moving_down && pos_next >= upper)) begin
            remaining <= '0;
            active <= 1'b0;
            fin <= 1'b1;
          end else begin
            remaining <= remaining - 24'd1;
          end
        end
        smpg_pkg::CMD_LOOKUP: begin
          if (elapsed < move_time)
            idx <= IdxW'((32'(div_q[15:0]) * 32'(COS_TABLE_DEPTH)) >> 16);
          else idx <= '0;
        end
        smpg_pkg::CMD_DIV_PER: ;
        smpg_pkg::CMD_TICK_DONE: begin
          if (v < 17'd66) cur_period <= smpg_pkg::PeriodMax;
          else if (|div_q[31:16]) cur_period <= smpg_pkg::PeriodMax;
          else if (div_q[15:0] < fastest) cur_period <= fastest;
          else cur_period <= div_q[15:0];
          if (elapsed != smpg_pkg::PeriodMax) elapsed <= elapsed + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    v <= 17'((19'sd65536 - 19'(cos_q)) >>> 1);
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_fin_idle, clk, rst, fin, !active)
  `ASSERT_IMPLIES(a_cmp_stop, clk, rst, !active, compare == 15'd0)
  `ASSERT_NEXT(a_div_start, clk, rst, div_start, div_busy)
endmodule

// File: design/smpg_ctrl.sv
// Controller: sequences one event through the datapath commands.
// Depends on smpg_pkg and assert_macros.svh.
module smpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  input  smpg_pkg::status_t status,
  output smpg_pkg::cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_AIM, S_BRANCH, S_PEAK, S_WPEAK, S_WFLAT, S_SPS, S_WSPS, S_WVEL,
    S_WT, S_LOOK, S_VCALC, S_WPER, S_FINISH, S_OUT
  } state_t;

  state_t state;
  logic [1:0] op;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.code = smpg_pkg::CMD_NONE;
    unique case (state)
      S_AIM:    cmd.code = smpg_pkg::CMD_AIM;
      S_PEAK:   cmd.code = smpg_pkg::CMD_DIV_PEAK;
      S_WPEAK:  if (!status.div_busy) cmd.code = smpg_pkg::CMD_DIV_FLAT;
      S_WFLAT:  if (!status.div_busy) cmd.code = smpg_pkg::CMD_TIMED_DONE;
      S_SPS:    cmd.code = smpg_pkg::CMD_MUL_SPS;
      S_WSPS:   cmd.code = smpg_pkg::CMD_DIV_SPS;
      S_FINISH: if (!status.div_busy) cmd.code = smpg_pkg::CMD_DIV_VEL;
      S_WVEL:   if (!status.div_busy) cmd.code = smpg_pkg::CMD_VEL_DONE;
      S_BRANCH: begin
        if (op == smpg_pkg::OP_STEP && status.active) cmd.code = smpg_pkg::CMD_STEP;
        else if (op == smpg_pkg::OP_TICK && status.active && status.profiled)
          cmd.code = smpg_pkg::CMD_DIV_T;
      end
      S_WT:     if (!status.div_busy) cmd.code = smpg_pkg::CMD_LOOKUP;
      S_VCALC:  cmd.code = smpg_pkg::CMD_DIV_PER;
      S_WPER:   if (!status.div_busy) cmd.code = smpg_pkg::CMD_TICK_DONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= '0;
    end else begin
      unique case (state)
        S_IDLE, S_OUT: if (cmd.load) begin
          op <= in_operation;
          state <= (in_operation == smpg_pkg::OP_TIMED ||
                    in_operation == smpg_pkg::OP_VELOCITY) ? S_AIM : S_BRANCH;
        end else if (state == S_OUT && out_ready) state <= S_IDLE;
        S_AIM: state <= S_BRANCH;
        S_BRANCH: begin
          if (op == smpg_pkg::OP_TIMED)
            state <= status.dist_zero ? S_OUT : S_PEAK;
          else if (op == smpg_pkg::OP_VELOCITY)
            state <= status.dist_zero ? S_OUT : S_SPS;
          else if (op == smpg_pkg::OP_TICK && status.active && status.profiled)
            state <= S_WT;
          else state <= S_OUT;
        end
        S_PEAK:  state <= S_WPEAK;
        S_WPEAK: if (!status.div_busy) state <= S_WFLAT;
        S_WFLAT: if (!status.div_busy) state <= S_OUT;
        S_SPS:   state <= S_WSPS;
        S_WSPS:  state <= S_FINISH;
        S_FINISH: if (!status.div_busy) state <= S_WVEL;
        S_WVEL: if (!status.div_busy) state <= S_OUT;
        S_WT:    if (!status.div_busy) state <= S_LOOK;
        S_LOOK:  state <= S_VCALC;
        S_VCALC: state <= S_WPER;
        S_WPER:  if (!status.div_busy) state <= S_OUT;
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLIES(a_ready_state, clk, rst, in_ready, state == S_IDLE || state == S_OUT)
  `ASSERT_NEXT(a_load_leaves, clk, rst, cmd.load, state != S_IDLE)
endmodule

// File: design/stepper_move_profile_generator.sv
// Top level of the stepper move profile generator.
// Depends on smpg_pkg, smpg_if, smpg_ctrl and smpg_datapath.
//
// Channels: an input word (operation, target_step, duration_ms, speed_mm_s)
// on the in channel, one result word (period, compare, running, direction,
// position, finished) on the out channel per input word, and a config write
// channel (index, data) that is always ready.
// From accept to result: a step or an idle tick passes through S_BRANCH to
// S_OUT, a move to the current position through S_AIM and S_BRANCH; a timed
// move, a velocity move or a profiled tick also waits on the shared
// bit-serial divider, which does two divisions in turn.
// One word is in flight at a time; the next is accepted in the cycle its
// result is taken.
// Reset: synchronous, clears position and move state, loads register
// defaults. A stalled receiver holds the result; no new word is taken.
module stepper_move_profile_generator #(
  parameter int COS_TABLE_DEPTH = smpg_pkg::CosTableDepth
) (
  input logic clk,
  input logic rst,
  smpg_if.sink   in,
  smpg_if.source out,
  smpg_if.sink   cfg
);
  smpg_pkg::cmd_t    cmd;
  smpg_pkg::status_t status;

  assign cfg.ready = 1'b1;

  smpg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .in_operation(in.data.operation), .out_valid(out.valid),
    .out_ready(out.ready), .status(status), .cmd(cmd)
  );

  smpg_datapath #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_target(in.data.target_step),
    .in_duration(in.data.duration_ms), .in_speed(in.data.speed_mm_s),
    .cfg_we(cfg.valid), .cfg_index(cfg.data.index), .cfg_data(cfg.data.data),
    .period(out.data.period), .compare(out.data.compare),
    .running(out.data.running), .direction(out.data.direction),
    .position(out.data.position), .finished(out.data.finished)
  );
endmodule

// File: sim/testbench.sv
// Self-checking bench for stepper_move_profile_generator: random and directed
// move, step and tick words against an in-bench profile predictor.
// Depends on smpg_pkg, smpg_if and the generator RTL.
module testbench;
  typedef struct packed {
    smpg_pkg::op_t operation;
    logic [23:0]   target_step;
    logic [15:0]   duration_ms;
    logic [9:0]    speed_mm_s;
  } move_word_t;

  typedef struct packed {
    logic [15:0] period;
    logic [14:0] compare;
    logic        running;
    logic        direction;
    logic [23:0] position;
    logic        finished;
  } result_word_t;

  typedef struct packed {
    smpg_pkg::reg_idx_t index;
    logic [23:0]        data;
  } cfg_word_t;

  class move_scoreboard;
    longint unsigned travel, margin, threshold, steps_rev, mm_rev;
    longint unsigned pos, remaining, elapsed, move_time, fastest, cur_period;
    bit down, active, profiled;
    longint cos_q16[256];
    result_word_t pending[$];
    int mismatches;

    function new();
      longint unsigned j, x, term;
      longint acc, r;
      for (int i = 0; i < 256; i++) begin
        j = (2 * i <= 256) ? i : 256 - i;
        x = (2 * 64'd843314857 * j) / 256;
        acc = 268435456;
        term = 268435456;
        for (int k = 1; k <= 12; k++) begin
          term = (term * x) >> 28;
          term = (term * x) >> 28;
          term = term / ((2 * k - 1) * (2 * k));
          if (k % 2) acc -= longint'(term);
          else acc += longint'(term);
        end
        if (acc >= 0) r = (acc + 2048) >>> 12;
        else r = -((-acc + 2048) >>> 12);
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        cos_q16[i] = r;
      end
      travel = 24'hFFFFFF; margin = 0; threshold = 667; steps_rev = 200; mm_rev = 8;
      pos = 0; remaining = 0; elapsed = 0; move_time = 0;
      fastest = 65535; cur_period = 65535;
      down = 0; active = 0; profiled = 0; mismatches = 0;
    endfunction

    function void write_reg(smpg_pkg::reg_idx_t idx, longint unsigned val);
      case (idx)
        smpg_pkg::REG_MAX_TRAVEL: travel = val & 24'hFFFFFF;
        smpg_pkg::REG_MARGIN:     margin = val & 16'hFFFF;
        smpg_pkg::REG_THRESHOLD:  threshold = val & 16'hFFFF;
        smpg_pkg::REG_STEPS_REV:  steps_rev = val & 16'hFFFF;
        smpg_pkg::REG_MM_REV:     mm_rev = val & 8'hFF;
        default: ;
      endcase
    endfunction

    function longint unsigned clamp_period(longint unsigned p);
      if (p < 1) return 1;
      if (p > 65535) return 65535;
      return p;
    endfunction

    function longint unsigned distance(longint unsigned target);
      if (target == pos) return 0;
      down = target < pos;
      return down ? pos - target : target - pos;
    endfunction

    function void note_word(move_word_t w);
      longint unsigned span, peak, mm, sps, t, idx, v, p, upper;
      result_word_t res;
      bit fin;
      fin = 0;
      case (w.operation)
        smpg_pkg::OP_TIMED: begin
          span = distance(w.target_step);
          if (span != 0) begin
            peak = clamp_period((w.duration_ms * 500) / span);
            elapsed = 0; move_time = w.duration_ms; remaining = span; active = 1;
            if (peak >= threshold) begin
              fastest = clamp_period((w.duration_ms * 1000) / span);
              cur_period = fastest; profiled = 0;
            end else begin
              fastest = peak; cur_period = 65535; profiled = 1;
            end
          end
        end
        smpg_pkg::OP_VELOCITY: begin
          span = distance(w.target_step);
          if (span != 0) begin
            mm = mm_rev ? mm_rev : 1;
            sps = (w.speed_mm_s * steps_rev) / mm;
            p = sps ? clamp_period(1000000 / sps) : 65535;
            remaining = span; fastest = p; cur_period = p; profiled = 0; active = 1;
          end
        end
        smpg_pkg::OP_STEP: begin
          if (active) begin
            remaining = (remaining - 1) & 24'hFFFFFF;
            pos = (down ? pos - 1 : pos + 1) & 24'hFFFFFF;
            upper = (travel > margin) ? travel - margin : 0;
            if (remaining == 0 || (down && pos <= margin) || (!down && pos >= upper)) begin
              remaining = 0; active = 0; fin = 1;
            end
          end
        end
        default: begin
          if (active && profiled) begin
            t = (elapsed < move_time) ? (elapsed << 16) / move_time : 0;
            idx = (t * 256) >> 16;
            if (idx >= 256) idx = 0;
            v = longint'(65536 - cos_q16[idx]) >>> 1;
            if (v < 66) p = 65535;
            else begin
              p = (fastest << 16) / v;
              if (p > 65535) p = 65535;
              if (p < fastest) p = fastest;
            end
            cur_period = p;
            if (elapsed < 65535) elapsed++;
          end
        end
      endcase
      res.period = cur_period[15:0];
      res.compare = active ? cur_period[15:1] : 15'd0;
      res.running = active;
      res.direction = down;
      res.position = pos[23:0];
      res.finished = fin;
      pending.push_back(res);
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want per %0d cmp %0d run %b dir %b pos %0d fin %b",
                   want.period, want.compare, want.running, want.direction,
                   want.position, want.finished);
          $display("          got  per %0d cmp %0d run %b dir %b pos %0d fin %b",
                   got.period, got.compare, got.running, got.direction,
                   got.position, got.finished);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  smpg_if #(.payload_t(move_word_t))   in_ch(clk);
  smpg_if #(.payload_t(result_word_t)) out_ch(clk);
  smpg_if #(.payload_t(cfg_word_t))    cfg_ch(clk);

  stepper_move_profile_generator u_dut (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  move_scoreboard sb = new();
  bit idle_on = 1;
  bit hold_req = 0;
  int unsigned cycles = 0;

  always begin
    clk = 1; #10;
    clk = 0; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(smpg_pkg::op_t op, logic [23:0] target, logic [15:0] dur,
                           logic [9:0] speed);
    move_word_t w;
    w.operation = op; w.target_step = target; w.duration_ms = dur; w.speed_mm_s = speed;
    in_ch.valid <= 1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(smpg_pkg::reg_idx_t idx, logic [23:0] val);
    cfg_word_t c;
    c.index = idx; c.data = val;
    cfg_ch.valid <= 1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_regs(logic [23:0] tr, logic [15:0] mg, logic [15:0] th,
                            logic [15:0] sr, logic [7:0] mm);
    drain();
    write_reg(smpg_pkg::REG_MAX_TRAVEL, tr);
    write_reg(smpg_pkg::REG_MARGIN, 24'(mg));
    write_reg(smpg_pkg::REG_THRESHOLD, 24'(th));
    write_reg(smpg_pkg::REG_STEPS_REV, 24'(sr));
    write_reg(smpg_pkg::REG_MM_REV, 24'(mm));
    cfg_ch.valid <= 0;
  endtask

  task automatic random_moves(int count);
    int n;
    longint unsigned tgt, span;
    n = 0;
    while (n < count) begin
      span = $urandom_range(1, 60);
      if ($urandom_range(0, 1) && sb.pos >= span) tgt = sb.pos - span;
      else tgt = sb.pos + span;
      case ($urandom_range(0, 9))
        0: send_word(smpg_pkg::op_t'($urandom_range(0, 3)), 24'($urandom), 16'($urandom),
                     10'($urandom));
        1, 2, 3: send_word(smpg_pkg::OP_VELOCITY, 24'(tgt), 16'($urandom),
                           10'($urandom_range(0, 1023)));
        default: send_word(smpg_pkg::OP_TIMED, 24'(tgt),
                           16'(($urandom_range(0, 3) == 0) ? $urandom
                               : $urandom_range(0, 32'(3 * span))),
                           10'($urandom));
      endcase
      n++;
      repeat ($urandom_range(2, 12)) begin
        send_word($urandom_range(0, 2) ? smpg_pkg::OP_TICK : smpg_pkg::OP_STEP,
                  24'($urandom), 16'($urandom), 10'($urandom));
        n++;
      end
      while (sb.active && $urandom_range(0, 3) != 0) begin
        send_word($urandom_range(0, 1) ? smpg_pkg::OP_STEP : smpg_pkg::OP_TICK,
                  24'($urandom), 16'($urandom), 10'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    rst = 1;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(smpg_pkg::OP_TIMED, 0, 100, 5);
    send_word(smpg_pkg::OP_STEP, 0, 0, 0);
    send_word(smpg_pkg::OP_TICK, 0, 0, 0);
    send_word(smpg_pkg::OP_VELOCITY, 24'hFFFFFF, 0, 0);
    send_word(smpg_pkg::OP_STEP, 0, 0, 0);
    send_word(smpg_pkg::OP_VELOCITY, 24'hFFFFFF, 0, 1023);
    send_word(smpg_pkg::OP_STEP, 0, 0, 0);
    send_word(smpg_pkg::OP_TIMED, 3, 16'hFFFF, 0);
    send_word(smpg_pkg::OP_TICK, 0, 0, 0);
    send_word(smpg_pkg::OP_STEP, 0, 0, 0);
    send_word(smpg_pkg::OP_TIMED, 100, 0, 0);
    repeat (3) send_word(smpg_pkg::OP_TICK, 0, 0, 0);
    send_word(smpg_pkg::OP_TIMED, 0, 40, 0);
    repeat (5) send_word(smpg_pkg::OP_TICK, 0, 0, 0);
    send_word(smpg_pkg::OP_STEP, 0, 0, 0);
    send_word(smpg_pkg::OP_TIMED, 24'(sb.pos), 40, 0);
    send_word(smpg_pkg::OP_STEP, 24'hFFFFFF, 16'hFFFF, 10'h3FF);

    hold_req = 1;
    random_moves(20);
    drain();

    apply_regs(200, 0, 667, 200, 8);
    random_moves(80);
    apply_regs(24'hFFFFFF, 16'hFFFF, 1, 65535, 1);
    random_moves(70);
    apply_regs(0, 0, 65535, 1, 255);
    random_moves(70);
    apply_regs(300, 20, 2000, 400, 5);
    random_moves(80);
    idle_on = 0;
    apply_regs(24'hFFFFFF, 5, 667, 200, 8);
    random_moves(80);

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
